FILE: hdl/slfr_pkg.sv
package slfr_pkg;

	localparam logic [7:0] SYNC_BYTE      = 8'hC1;
	localparam logic [7:0] MAP_MASK       = 8'hE0;
	localparam logic [7:0] MAP_MAJOR      = 8'hA0;
	localparam logic [7:0] TYPE_KEY       = 8'h00;
	localparam logic [7:0] SMALL_UINT_MAX = 8'h17;
	localparam logic [7:0] UINT8_FOLLOWS  = 8'h18;

	localparam logic [15:0] MAX_LEN_RESET = 16'd256;
	localparam int          HEAD_DEPTH    = 4;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_LEN_HI  = 2'd1,
		PH_LEN_LO  = 2'd2,
		PH_PAYLOAD = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		EV_DISCARD = 3'd0,
		EV_HEADER  = 3'd1,
		EV_BAD_LEN = 3'd2,
		EV_PAYLOAD = 3'd3,
		EV_DELIVER = 3'd4,
		EV_DROP    = 3'd5
	} event_t;

	typedef logic [HEAD_DEPTH-1:0][7:0] head_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] mtype;
	} prefix_res_t;

endpackage

FILE: hdl/slfr_if.sv
interface slfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface slfr_evt_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [7:0]  payload_byte;
	logic [15:0] byte_index;
	logic [7:0]  message_type;
	logic [15:0] frame_length;

	modport source (output valid, output event_res, output payload_byte,
		output byte_index, output message_type, output frame_length, input ready);
	modport sink (input valid, input event_res, input payload_byte,
		input byte_index, input message_type, input frame_length, output ready);
endinterface

interface slfr_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] max_payload_len;

	modport source (output valid, output max_payload_len, input ready);
	modport sink (input valid, input max_payload_len, output ready);
endinterface

FILE: hdl/slfr_prefix_check.sv
module slfr_prefix_check
	import slfr_pkg::*;
(
	input  head_t       head,
	input  logic [15:0] len,
	output prefix_res_t res
);

	logic len_ge2;
	logic len_ge3;
	logic len_ge4;

	assign len_ge2 = (len >= 16'd2);
	assign len_ge3 = (len >= 16'd3);
	assign len_ge4 = (len >= 16'd4);

	always_comb begin
		res.ok    = 1'b0;
		res.mtype = 8'd0;
		if (len_ge2 && ((head[0] & MAP_MASK) == MAP_MAJOR) && (head[1] == TYPE_KEY)
				&& len_ge3) begin
			if (head[2] <= SMALL_UINT_MAX) begin
				res.ok    = 1'b1;
				res.mtype = head[2];
			end else if ((head[2] == UINT8_FOLLOWS) && len_ge4) begin
				res.ok    = 1'b1;
				res.mtype = head[3];
			end
		end
	end

endmodule

FILE: hdl/sync_length_frame_receiver.sv
// Channel  Role    Word
// rx       sink    one received byte (rx_byte)
// evt      source  event_res, payload_byte, byte_index, message_type, frame_length
// cfg      sink    max_payload_len write, always ready
//
// Each accepted byte yields one event word in the next cycle; one byte per
// cycle while rx.ready is high. The per-byte work is the frame state update plus
// the prefix check, all in the cycle of acceptance, landing in the event output
// register. rx.ready drops only while the event register is full and evt.ready is
// low. Reset returns to hunting for the sync byte, with max_payload_len at 256.
module sync_length_frame_receiver
	import slfr_pkg::*;
(
	input logic           clk,
	input logic           arst_n,
	slfr_rx_if.sink       rx,
	slfr_evt_if.source    evt,
	slfr_cfg_if.sink      cfg
);

	phase_t      phase_q, phase_d;
	logic [15:0] exp_q, exp_d;
	logic [15:0] count_q, count_d;
	logic [15:0] max_q;
	head_t       head_q;
	head_t       head_view;
	logic        accept;
	logic        head_wr;
	logic [15:0] count_inc;
	logic [15:0] len_full;
	logic        len_bad;
	logic        last_byte;
	prefix_res_t prefix;

	event_t      ev;
	logic [7:0]  pb;
	logic [15:0] idx;
	logic [7:0]  mtype;
	logic [15:0] flen;

	logic        out_valid_q;
	event_t      ev_q;
	logic [7:0]  pb_q;
	logic [15:0] idx_q;
	logic [7:0]  mtype_q;
	logic [15:0] flen_q;

	assign rx.ready  = !out_valid_q || evt.ready;
	assign accept    = rx.valid && rx.ready;
	assign cfg.ready = 1'b1;

	assign count_inc = count_q + 16'd1;
	assign last_byte = (count_inc == exp_q);
	assign len_full  = {exp_q[15:8], rx.rx_byte};
	assign len_bad   = (len_full == 16'd0) || (len_full > max_q);
	assign head_wr   = (phase_q == PH_PAYLOAD) && (count_q[15:2] == 14'd0);

	// The byte arriving now counts toward the prefix if it is one of the first four.
	always_comb begin
		for (int i = 0; i < HEAD_DEPTH; i++) begin
			if (head_wr && (count_q[1:0] == 2'(i))) begin
				head_view[i] = rx.rx_byte;
			end else begin
				head_view[i] = head_q[i];
			end
		end
	end

	slfr_prefix_check u_prefix (
		.head (head_view),
		.len  (exp_q),
		.res  (prefix)
	);

	always_comb begin
		phase_d = phase_q;
		exp_d   = exp_q;
		count_d = count_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx.rx_byte == SYNC_BYTE) begin
					phase_d = PH_LEN_HI;
					exp_d   = 16'd0;
				end
			end
			PH_LEN_HI: begin
				phase_d = PH_LEN_LO;
				exp_d   = {rx.rx_byte, 8'd0};
			end
			PH_LEN_LO: begin
				exp_d   = len_full;
				count_d = 16'd0;
				phase_d = len_bad ? PH_HUNT : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				count_d = count_inc;
				if (last_byte) begin
					phase_d = PH_HUNT;
				end
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	always_comb begin
		ev    = EV_DISCARD;
		pb    = 8'd0;
		idx   = 16'd0;
		mtype = 8'd0;
		flen  = 16'd0;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx.rx_byte == SYNC_BYTE) begin
					ev = EV_HEADER;
				end
			end
			PH_LEN_HI: begin
				ev   = EV_HEADER;
				flen = {rx.rx_byte, 8'd0};
			end
			PH_LEN_LO: begin
				ev   = len_bad ? EV_BAD_LEN : EV_HEADER;
				flen = len_full;
			end
			PH_PAYLOAD: begin
				pb   = rx.rx_byte;
				idx  = count_q;
				flen = exp_q;
				if (!last_byte) begin
					ev = EV_PAYLOAD;
				end else if (prefix.ok) begin
					ev    = EV_DELIVER;
					mtype = prefix.mtype;
				end else begin
					ev = EV_DROP;
				end
			end
			default: ev = EV_DISCARD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			exp_q   <= 16'd0;
			count_q <= 16'd0;
			max_q   <= MAX_LEN_RESET;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				exp_q   <= exp_d;
				count_q <= count_d;
			end
			if (cfg.valid && cfg.ready) begin
				max_q <= cfg.max_payload_len;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && head_wr) begin
			head_q[count_q[1:0]] <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ev_q    <= ev;
			pb_q    <= pb;
			idx_q   <= idx;
			mtype_q <= mtype;
			flen_q  <= flen;
		end
	end

	assign evt.valid        = out_valid_q;
	assign evt.event_res    = ev_q;
	assign evt.payload_byte = pb_q;
	assign evt.byte_index   = idx_q;
	assign evt.message_type = mtype_q;
	assign evt.frame_length = flen_q;

endmodule

FILE: dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import slfr_pkg::*;

	typedef struct packed {
		event_t      ev;
		logic [7:0]  pb;
		logic [15:0] idx;
		logic [7:0]  mtype;
		logic [15:0] flen;
	} evt_word_t;

	logic clk = 1'b0;
	logic arst_n;

	slfr_rx_if  rx_ch ();
	slfr_evt_if evt_ch ();
	slfr_cfg_if cfg_ch ();

	sync_length_frame_receiver DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.evt    (evt_ch),
		.cfg    (cfg_ch)
	);

	always #4 clk = ~clk;

	// Shadow copy of the deframer state.
	logic [15:0] model_max;
	phase_t      model_phase;
	logic [15:0] model_len;
	logic [15:0] model_count;
	logic [7:0]  model_head [HEAD_DEPTH];

	evt_word_t pending_events [$];

	int  mismatches;
	int  bytes_sent;
	int  n_deliver;
	int  n_drop;
	int  n_badlen;
	int  n_settings;
	bit  src_idle;
	bit  sink_idle;
	int  cur_max;

	function automatic evt_word_t frame_step(input logic [7:0] b);
		evt_word_t  w;
		logic       ok;
		logic [7:0] t;
		w = '0;
		w.ev = EV_DISCARD;
		ok = 1'b0;
		t = 8'h00;
		case (model_phase)
			PH_HUNT: begin
				if (b == SYNC_BYTE) begin
					model_len = '0;
					model_phase = PH_LEN_HI;
					w.ev = EV_HEADER;
				end
			end
			PH_LEN_HI: begin
				model_len = {b, 8'h00};
				model_phase = PH_LEN_LO;
				w.ev = EV_HEADER;
				w.flen = model_len;
			end
			PH_LEN_LO: begin
				model_len = model_len | {8'h00, b};
				model_count = '0;
				w.flen = model_len;
				if (model_len == 16'd0 || model_len > model_max) begin
					model_phase = PH_HUNT;
					w.ev = EV_BAD_LEN;
				end else begin
					model_phase = PH_PAYLOAD;
					w.ev = EV_HEADER;
				end
			end
			default: begin
				if (model_count < HEAD_DEPTH)
					model_head[model_count[1:0]] = b;
				w.idx = model_count;
				w.pb = b;
				w.flen = model_len;
				model_count = model_count + 16'd1;
				if (model_count == model_len) begin
					// The prefix needs a map header, key 0 and a type that fits in the frame.
					if (model_len >= 16'd3 && (model_head[0] & MAP_MASK) == MAP_MAJOR &&
							model_head[1] == TYPE_KEY) begin
						if (model_head[2] <= SMALL_UINT_MAX) begin
							ok = 1'b1;
							t = model_head[2];
						end else if (model_head[2] == UINT8_FOLLOWS && model_len >= 16'd4) begin
							ok = 1'b1;
							t = model_head[3];
						end
					end
					w.ev = ok ? EV_DELIVER : EV_DROP;
					w.mtype = t;
					model_phase = PH_HUNT;
				end else begin
					w.ev = EV_PAYLOAD;
				end
			end
		endcase
		return w;
	endfunction

	// Register writes and accepted bytes update the shadow state before the
	// event word of the same edge is checked.
	always @(posedge clk) begin : scoreboard
		evt_word_t got;
		evt_word_t want;
		if (cfg_ch.valid && cfg_ch.ready)
			model_max = cfg_ch.max_payload_len;
		if (rx_ch.valid && rx_ch.ready)
			pending_events.push_back(frame_step(rx_ch.rx_byte));
		if (evt_ch.valid && evt_ch.ready) begin
			got.ev = event_t'(evt_ch.event_res);
			got.pb = evt_ch.payload_byte;
			got.idx = evt_ch.byte_index;
			got.mtype = evt_ch.message_type;
			got.flen = evt_ch.frame_length;
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word at %0t: ev=%0d pb=%02h idx=%0d type=%02h len=%0d",
						$time, got.ev, got.pb, got.idx, got.mtype, got.flen);
			end else begin
				want = pending_events.pop_front();
				if (got.ev !== want.ev || got.pb !== want.pb || got.idx !== want.idx ||
						got.mtype !== want.mtype || got.flen !== want.flen) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch at %0t: expected ev=%0d pb=%02h idx=%0d type=%02h len=%0d",
							$time, want.ev, want.pb, want.idx, want.mtype, want.flen);
						$display("                   got ev=%0d pb=%02h idx=%0d type=%02h len=%0d",
							got.ev, got.pb, got.idx, got.mtype, got.flen);
					end
				end
			end
			case (got.ev)
				EV_DELIVER: n_deliver++;
				EV_DROP:    n_drop++;
				EV_BAD_LEN: n_badlen++;
				default: ;
			endcase
		end
	end

	always @(posedge clk)
		evt_ch.ready <= !(sink_idle && ($urandom_range(0, 99) < 16));

	task automatic send_byte(input logic [7:0] b);
		while (src_idle && ($urandom_range(0, 99) < 16)) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// The first edge lets the scoreboard record the last accepted byte.
	task automatic drain();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_max_len(input logic [15:0] v);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.max_payload_len <= v;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		cur_max = int'(v);
		n_settings++;
	endtask

	task automatic send_frame(input logic [15:0] len, input logic [7:0] body [$]);
		send_byte(SYNC_BYTE);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		foreach (body[i])
			send_byte(body[i]);
	endtask

	// Mostly well-formed frames with random content, plus noise, refused lengths,
	// fully random bodies and frames whose prefix is broken in one place.
	task automatic send_random_frame();
		int          kind;
		int          n;
		int          lim;
		logic [15:0] len;
		logic [7:0]  body [$];
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 4))
				send_byte(8'($urandom_range(0, 255)));
		end else if (kind < 16) begin
			if (cur_max == 65535 || $urandom_range(0, 1) == 0)
				len = 16'd0;
			else
				len = 16'($urandom_range(cur_max + 1, 65535));
			send_frame(len, body);
		end else begin
			lim = (cur_max < 12) ? cur_max : 12;
			if ($urandom_range(0, 19) == 0)
				lim = (cur_max < 300) ? cur_max : 300;
			if (lim == 0)
				lim = 4;
			n = $urandom_range(1, lim);
			repeat (n) body.push_back(8'($urandom_range(0, 255)));
			if (kind < 85) begin
				body[0] = 8'hA0 | 8'($urandom_range(0, 31));
				if (n > 1)
					body[1] = TYPE_KEY;
				if (n > 2)
					body[2] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 23)) :
						UINT8_FOLLOWS;
				if (kind >= 70) begin
					case ($urandom_range(0, 2))
						0: body[0][7:5] = 3'b101 ^ 3'($urandom_range(1, 7));
						1: if (n > 1) body[1] = 8'($urandom_range(1, 255));
						default: if (n > 2) body[2] = 8'($urandom_range(25, 255));
					endcase
				end
			end
			send_frame(16'(n), body);
		end
	endtask

	task automatic test_directed();
		logic [7:0] none [$];
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(16'd0, none);
		send_frame(16'd257, none);
		// A sync byte inside a frame is plain data; a one-byte frame always drops.
		send_frame(16'd1, '{SYNC_BYTE});
		send_frame(16'd4, '{8'hA0, 8'h00, UINT8_FOLLOWS, 8'hFF});
		send_frame(16'd3, '{8'hBF, 8'h00, SMALL_UINT_MAX});
		send_frame(16'd2, '{8'hA1, 8'h00});
		set_max_len(16'd0);
		send_frame(16'd1, none);
		send_frame(16'd0, none);
		set_max_len(16'd1);
		send_frame(16'd1, '{8'hA5});
		send_frame(16'd2, none);
	endtask

	task automatic test_random();
		int settings [7];
		int target;
		settings = '{16, 1, 0, 65535, 0, 3, 256};
		settings[4] = $urandom_range(2, 700);
		foreach (settings[p]) begin
			set_max_len(16'(settings[p]));
			// One phase runs with both sides at full rate.
			src_idle = (p != 5);
			sink_idle = (p != 5);
			target = bytes_sent + 150;
			while (bytes_sent < target)
				send_random_frame();
		end
		src_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	task automatic test_pause();
		set_max_len(MAX_LEN_RESET);
		repeat (8) begin
			send_random_frame();
			drain();
		end
	endtask

	task automatic test_long_frame();
		logic [7:0] none [$];
		logic [7:0] body [$];
		set_max_len(16'hFFFE);
		send_frame(16'hFFFF, none);
		set_max_len(16'hFFFF);
		body = '{8'hA0, 8'h00, UINT8_FOLLOWS};
		body.push_back(8'($urandom_range(0, 255)));
		while (body.size() < 256)
			body.push_back(8'($urandom_range(0, 255)));
		send_frame(16'd256, body);
	endtask

	initial begin
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= 8'h00;
		cfg_ch.valid <= 1'b0;
		cfg_ch.max_payload_len <= MAX_LEN_RESET;
		arst_n <= 1'b0;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		cur_max = int'(MAX_LEN_RESET);
		model_max = MAX_LEN_RESET;
		model_phase = PH_HUNT;
		model_len = '0;
		model_count = '0;
		foreach (model_head[i])
			model_head[i] = 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random();
		test_pause();
		test_long_frame();

		drain();
		if (pending_events.size() != 0)
			mismatches++;
		$display("Sent %0d bytes over %0d register settings: %0d frames delivered, %0d dropped,",
			bytes_sent, n_settings, n_deliver, n_drop);
		$display("%0d lengths refused, %0d mismatches.", n_badlen, mismatches);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
hdl/slfr_pkg.sv
hdl/slfr_if.sv
hdl/slfr_prefix_check.sv
hdl/sync_length_frame_receiver.sv
dv/testbench.sv
